// ===== design/w2s_pkg.sv =====
// shared types, constants and helper functions of the world-to-screen projection
package w2s_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ROW_X_FIRST  = 3'd0;
  localparam logic [2:0] REG_ROW_X_SECOND = 3'd1;
  localparam logic [2:0] REG_ROW_Y_FIRST  = 3'd2;
  localparam logic [2:0] REG_ROW_Y_SECOND = 3'd3;
  localparam logic [2:0] REG_ROW_W_FIRST  = 3'd4;
  localparam logic [2:0] REG_ROW_W_SECOND = 3'd5;
  localparam logic [2:0] REG_WIDTH        = 3'd6;
  localparam logic [2:0] REG_HEIGHT       = 3'd7;

  // reset values
  localparam logic [63:0] PAIR_ONE_LOW  = 64'd1048576;
  localparam logic [63:0] PAIR_ONE_HIGH = 64'd4503599627370496;
  localparam logic [13:0] WIDTH_RESET   = 14'd1920;
  localparam logic [13:0] HEIGHT_RESET  = 14'd1080;

  // quotient bits resolved by the divider; larger quotients are clamped
  localparam int QBITS = 25;
  // clip value width (Q.8, unsaturated)
  localparam int CW = 38;
  // scaled numerator width
  localparam int NW = 56;
  // divisor width (twice |w|)
  localparam int EW = CW + 1;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
  } in_t;

  typedef struct packed {
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic signed [31:0] depth_w;
    logic               depth_is_zero;
  } out_t;

  typedef struct packed {
    logic [63:0] x_first;
    logic [63:0] x_second;
    logic [63:0] y_first;
    logic [63:0] y_second;
    logic [63:0] w_first;
    logic [63:0] w_second;
  } matrix_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] w;
  } clip_t;

  // fields that ride alongside the division
  typedef struct packed {
    logic signed [31:0] depth_w;
    logic               w_zero;
    logic               cx_neg;
    logic               cy_neg;
  } side_t;

  typedef struct packed {
    logic [EW-1:0]    rem;
    logic [QBITS-1:0] dq;
  } div_step_t;

  // one restoring division step: dividend bits shift out, quotient bits shift in
  function automatic div_step_t div_step(input logic [EW-1:0] rem,
                                         input logic [QBITS-1:0] dq,
                                         input logic [EW-1:0] divisor);
    logic [EW:0] trial;
    logic [EW:0] diff;
    div_step_t   r;
    trial = {rem, dq[QBITS-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      r.rem = diff[EW-1:0];
      r.dq  = {dq[QBITS-2:0], 1'b1};
    end else begin
      r.rem = trial[EW-1:0];
      r.dq  = {dq[QBITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    if (v > CW'(64'sd2147483647)) begin
      return 32'sh7FFFFFFF;
    end else if (v < -CW'(64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== design/w2s_transform.sv =====
// three-stage matrix transform: products, partial sums, final sum with rounding to Q.8
module w2s_transform (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  w2s_pkg::in_t      in_item,
  input  w2s_pkg::matrix_t  matrix,
  output logic              clip_valid,
  output w2s_pkg::clip_t    clip
);

  logic signed [31:0] coef [3][4];
  logic [63:0]        pair_a [3];
  logic [63:0]        pair_b [3];

  logic               v1, v2;
  logic signed [55:0] prod [3][3];
  logic signed [39:0] cst  [3];
  logic signed [56:0] sum_a [3];
  logic signed [56:0] sum_b [3];
  logic signed [57:0] total [3];

  // unpack coefficient rows x, y, w
  always_comb begin
    pair_a[0] = matrix.x_first;
    pair_b[0] = matrix.x_second;
    pair_a[1] = matrix.y_first;
    pair_b[1] = matrix.y_second;
    pair_a[2] = matrix.w_first;
    pair_b[2] = matrix.w_second;
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = pair_a[r][31:0];
      coef[r][1] = pair_a[r][63:32];
      coef[r][2] = pair_b[r][31:0];
      coef[r][3] = pair_b[r][63:32];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      clip_valid <= 1'b0;
    end else if (en) begin
      v1         <= in_valid;
      v2         <= v1;
      clip_valid <= v2;
    end
  end

  // rounded row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      total[r] = 58'(sum_a[r]) + 58'(sum_b[r]) + 58'sd524288;
    end
  end

  // product, partial sum and rounding stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= 56'(coef[r][0]) * 56'(in_item.world_x);
        prod[r][1] <= 56'(coef[r][1]) * 56'(in_item.world_y);
        prod[r][2] <= 56'(coef[r][2]) * 56'(in_item.world_z);
        cst[r]     <= {coef[r][3], 8'b0};
        sum_a[r]   <= 57'(prod[r][0]) + 57'(prod[r][1]);
        sum_b[r]   <= 57'(prod[r][2]) + 57'(cst[r]);
      end
      clip.cx <= total[0][57:20];
      clip.cy <= total[1][57:20];
      clip.w  <= total[2][57:20];
    end
  end

endmodule

// ===== design/w2s_divider.sv =====
// pipelined rounding divider for both scaled clip values over a shared depth divisor
module w2s_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [w2s_pkg::NW-1:0] nx,
  input  logic signed [w2s_pkg::NW-1:0] ny,
  input  logic signed [w2s_pkg::CW-1:0] w,
  input  w2s_pkg::side_t                side_in,
  output logic                          out_valid,
  output logic signed [w2s_pkg::QBITS+1:0] qx,
  output logic signed [w2s_pkg::QBITS+1:0] qy,
  output w2s_pkg::side_t                side_out
);

  localparam int Q  = w2s_pkg::QBITS;
  localparam int EW = w2s_pkg::EW;
  localparam int NW = w2s_pkg::NW;
  localparam int CW = w2s_pkg::CW;

  // stage a: magnitudes and quotient signs
  logic              va;
  logic [NW-1:0]     ux_a, uy_a;
  logic [CW-1:0]     ud_a;
  logic              negx_a, negy_a;
  w2s_pkg::side_t    side_a;

  // stage b: rounded dividend and doubled divisor
  logic              vb;
  logic [NW:0]       dx_b, dy_b;
  logic [EW-1:0]     e_b;
  logic              negx_b, negy_b;
  w2s_pkg::side_t    side_b;

  // iteration line, entry zero is the overflow check stage
  logic              vi    [Q+1];
  logic [EW-1:0]     rx    [Q+1];
  logic [EW-1:0]     ry    [Q+1];
  logic [Q-1:0]      dqx   [Q+1];
  logic [Q-1:0]      dqy   [Q+1];
  logic              ovx   [Q+1];
  logic              ovy   [Q+1];
  logic              negx  [Q+1];
  logic              negy  [Q+1];
  logic [EW-1:0]     ediv  [Q+1];
  w2s_pkg::side_t    side_i [Q+1];

  w2s_pkg::div_step_t stx [Q+1];
  w2s_pkg::div_step_t sty [Q+1];
  logic [Q:0]         magx, magy;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= Q; k++) begin
        vi[k] <= 1'b0;
      end
    end else if (en) begin
      va    <= in_valid;
      vb    <= va;
      vi[0] <= vb;
      for (int k = 1; k <= Q; k++) begin
        vi[k] <= vi[k-1];
      end
      out_valid <= vi[Q];
    end
  end

  // one quotient bit per stage
  always_comb begin
    stx[0] = '0;
    sty[0] = '0;
    for (int k = 1; k <= Q; k++) begin
      stx[k] = w2s_pkg::div_step(rx[k-1], dqx[k-1], ediv[k-1]);
      sty[k] = w2s_pkg::div_step(ry[k-1], dqy[k-1], ediv[k-1]);
    end
    magx = ovx[Q] ? (Q+1)'(1) << Q : {1'b0, dqx[Q]};
    magy = ovy[Q] ? (Q+1)'(1) << Q : {1'b0, dqy[Q]};
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      ux_a   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      uy_a   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      ud_a   <= w[CW-1] ? CW'(-w) : CW'(w);
      negx_a <= nx[NW-1] ^ w[CW-1];
      negy_a <= ny[NW-1] ^ w[CW-1];
      side_a <= side_in;

      dx_b   <= {ux_a, 1'b0} + (NW+1)'(ud_a);
      dy_b   <= {uy_a, 1'b0} + (NW+1)'(ud_a);
      e_b    <= {ud_a, 1'b0};
      negx_b <= negx_a;
      negy_b <= negy_a;
      side_b <= side_a;

      // quotient at or above 2^Q saturates the screen position anyway
      ovx[0]    <= EW'(dx_b[NW:Q]) >= e_b;
      ovy[0]    <= EW'(dy_b[NW:Q]) >= e_b;
      rx[0]     <= EW'(dx_b[NW:Q]);
      ry[0]     <= EW'(dy_b[NW:Q]);
      dqx[0]    <= dx_b[Q-1:0];
      dqy[0]    <= dy_b[Q-1:0];
      negx[0]   <= negx_b;
      negy[0]   <= negy_b;
      ediv[0]   <= e_b;
      side_i[0] <= side_b;

      for (int k = 1; k <= Q; k++) begin
        rx[k]     <= stx[k].rem;
        ry[k]     <= sty[k].rem;
        dqx[k]    <= stx[k].dq;
        dqy[k]    <= sty[k].dq;
        ovx[k]    <= ovx[k-1];
        ovy[k]    <= ovy[k-1];
        negx[k]   <= negx[k-1];
        negy[k]   <= negy[k-1];
        ediv[k]   <= ediv[k-1];
        side_i[k] <= side_i[k-1];
      end

      qx       <= negx[Q] ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
      qy       <= negy[Q] ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
      side_out <= side_i[Q];
    end
  end

endmodule

// ===== design/w2s_out_buffer.sv =====
// two-entry output buffer that decouples the pipeline from the result consumer
module w2s_out_buffer (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  w2s_pkg::out_t push_item,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output w2s_pkg::out_t out_item
);

  logic          head_v, tail_v;
  w2s_pkg::out_t tail_item;
  logic          pop;

  assign pop       = head_v && out_ready;
  assign out_valid = head_v;
  assign full      = tail_v;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= 1'b0;
      tail_v <= 1'b0;
    end else if (pop) begin
      head_v <= tail_v || push;
      tail_v <= tail_v && push;
    end else if (push) begin
      head_v <= 1'b1;
      tail_v <= head_v;
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (pop) begin
      if (tail_v) begin
        out_item <= tail_item;
        if (push) begin
          tail_item <= push_item;
        end
      end else if (push) begin
        out_item <= push_item;
      end
    end else if (push) begin
      if (head_v) begin
        tail_item <= push_item;
      end else begin
        out_item <= push_item;
      end
    end
  end

`ifndef SYNTH
  a_tail_needs_head: assert property (@(posedge clk) disable iff (rst) tail_v |-> head_v)
    else $error("tail entry valid without head entry");
  a_fill: assert property (@(posedge clk) disable iff (rst)
      (push && !pop && head_v) |=> tail_v)
    else $error("pushed item lost while head held");
  a_drain: assert property (@(posedge clk) disable iff (rst)
      (pop && tail_v && !push) |=> (head_v && !tail_v))
    else $error("buffered item not moved to head");
`endif

endmodule

// ===== design/world_to_screen_projection_top.sv =====
// top level of the world-to-screen projection pipeline
// Projects one world point (Q15.8) per clock to screen pixels (3 fraction bits)
// plus the Q23.8 depth. Sustained rate is one item per cycle while in_ready is
// high; from input accept to result valid an item passes 3 transform stages
// (multiply, partial sum, round), 1 viewport scale multiply, 29 divider stages
// (25 of them resolve one quotient bit each) and the output register. A two-entry
// output buffer holds results while the consumer stalls; in_ready drops
// only when both entries are occupied. Matrix and viewport registers are
// written through cfg_write/cfg_index/cfg_data and must be stable while
// items are in flight.
module world_to_screen_projection_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  w2s_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output w2s_pkg::out_t out_item
);

  localparam int CW = w2s_pkg::CW;
  localparam int NW = w2s_pkg::NW;
  localparam int Q  = w2s_pkg::QBITS;

  w2s_pkg::matrix_t matrix;
  logic [13:0]      width_px, height_px;

  logic             en, full;
  logic             clip_valid;
  w2s_pkg::clip_t   clip;

  logic                 sv;
  logic signed [NW-1:0] nx, ny;
  logic signed [CW-1:0] ws;
  w2s_pkg::side_t       side_s;

  logic                 dv;
  logic signed [Q+1:0]  qx, qy;
  w2s_pkg::side_t       side_d;

  logic signed [27:0]   sum_x, sum_y;
  w2s_pkg::out_t        result;

  assign en       = !full;
  assign in_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.x_first  <= w2s_pkg::PAIR_ONE_LOW;
      matrix.x_second <= '0;
      matrix.y_first  <= w2s_pkg::PAIR_ONE_HIGH;
      matrix.y_second <= '0;
      matrix.w_first  <= '0;
      matrix.w_second <= w2s_pkg::PAIR_ONE_HIGH;
      width_px        <= w2s_pkg::WIDTH_RESET;
      height_px       <= w2s_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        w2s_pkg::REG_ROW_X_FIRST:  matrix.x_first  <= cfg_data;
        w2s_pkg::REG_ROW_X_SECOND: matrix.x_second <= cfg_data;
        w2s_pkg::REG_ROW_Y_FIRST:  matrix.y_first  <= cfg_data;
        w2s_pkg::REG_ROW_Y_SECOND: matrix.y_second <= cfg_data;
        w2s_pkg::REG_ROW_W_FIRST:  matrix.w_first  <= cfg_data;
        w2s_pkg::REG_ROW_W_SECOND: matrix.w_second <= cfg_data;
        w2s_pkg::REG_WIDTH:        width_px        <= cfg_data[13:0];
        w2s_pkg::REG_HEIGHT:       height_px       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  w2s_transform u_transform (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .matrix     (matrix),
    .clip_valid (clip_valid),
    .clip       (clip)
  );

  // viewport scale stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (en) begin
      sv <= clip_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx             <= NW'($signed({1'b0, width_px, 3'b0})) * NW'(clip.cx);
      ny             <= NW'($signed({1'b0, height_px, 3'b0})) * NW'(clip.cy);
      ws             <= clip.w;
      side_s.depth_w <= w2s_pkg::sat32(clip.w);
      side_s.w_zero  <= (clip.w == '0);
      side_s.cx_neg  <= clip.cx[CW-1];
      side_s.cy_neg  <= clip.cy[CW-1];
    end
  end

  w2s_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sv),
    .nx        (nx),
    .ny        (ny),
    .w         (ws),
    .side_in   (side_s),
    .out_valid (dv),
    .qx        (qx),
    .qy        (qy),
    .side_out  (side_d)
  );

  // viewport offset, saturation and zero-depth override
  always_comb begin
    sum_x = 28'({width_px, 3'b0}) + 28'sd8 + 28'(qx);
    sum_y = 28'({height_px, 3'b0}) - 28'sd8 - 28'(qy);
    result.depth_w       = side_d.w_zero ? 32'sd0 : side_d.depth_w;
    result.depth_is_zero = side_d.w_zero;
    if (side_d.w_zero) begin
      result.screen_x = side_d.cx_neg ? 24'sh800000 : 24'sh7FFFFF;
      result.screen_y = side_d.cy_neg ? 24'sh7FFFFF : 24'sh800000;
    end else begin
      result.screen_x = w2s_pkg::sat24(sum_x);
      result.screen_y = w2s_pkg::sat24(sum_y);
    end
  end

  w2s_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (dv && en),
    .push_item (result),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTH
  a_zero_depth_out: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_item.depth_is_zero) |-> (out_item.depth_w == 32'sd0))
    else $error("zero depth flagged with nonzero depth");
  a_zero_depth_sat: assert property (@(posedge clk) disable iff (rst)
      (out_valid && out_item.depth_is_zero) |->
      ((out_item.screen_x == 24'sh7FFFFF || out_item.screen_x == 24'sh800000) &&
       (out_item.screen_y == 24'sh7FFFFF || out_item.screen_y == 24'sh800000)))
    else $error("zero depth item not saturated");
  a_stall_holds_divider: assert property (@(posedge clk) disable iff (rst)
      (!en && dv) |=> dv)
    else $error("divider result dropped during stall");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking testbench for the world-to-screen projection pipeline
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_write = 1'b0;
  logic [2:0]    cfg_index = w2s_pkg::REG_ROW_X_FIRST;
  logic [63:0]   cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  w2s_pkg::in_t  in_item = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  w2s_pkg::out_t out_item;

  world_to_screen_projection_top i_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  // mirror of the matrix and viewport registers
  logic [63:0] pair_reg [6];
  longint      view_w;
  longint      view_h;

  w2s_pkg::in_t  point_q [$];
  w2s_pkg::out_t projected_q [$];
  int     error_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_requests = 0;
  int     hold_served = 0;
  int     hold_left = 0;
  bit     in_taken = 0;
  longint cycle_count = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint coef(int pair, bit upper);
    logic [31:0] e;
    e = upper ? pair_reg[pair][63:32] : pair_reg[pair][31:0];
    return longint'(signed'(e));
  endfunction

  // one matrix row, rounded to Q.8 with floor, unsaturated
  function automatic longint clip_row(int first, longint x, longint y, longint z);
    longint s;
    s = coef(first, 0) * x + coef(first, 1) * y + coef(first + 1, 0) * z
      + coef(first + 1, 1) * 256;
    return (s + (longint'(1) <<< 19)) >>> 20;
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic longint div_round(longint n, longint d);
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    un = n < 0 ? longint'(-n) : n;
    ud = d < 0 ? longint'(-d) : d;
    q = (2 * un + ud) / (2 * ud);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic w2s_pkg::out_t project_point(w2s_pkg::in_t p);
    longint        cx, cy, w, sx, sy;
    w2s_pkg::out_t r;
    cx = clip_row(0, p.world_x, p.world_y, p.world_z);
    cy = clip_row(2, p.world_x, p.world_y, p.world_z);
    w  = clip_row(4, p.world_x, p.world_y, p.world_z);
    if (w == 0) begin
      sx = cx >= 0 ? 64'sd8388607 : -64'sd8388608;
      sy = cy >= 0 ? -64'sd8388608 : 64'sd8388607;
    end else begin
      sx = clamp(8 * view_w + 8 + div_round(8 * view_w * cx, w), 24);
      sy = clamp(8 * view_h - (div_round(8 * view_h * cy, w) + 8), 24);
    end
    r.screen_x = sx[23:0];
    r.screen_y = sy[23:0];
    r.depth_w = 32'(clamp(w, 32));
    r.depth_is_zero = (w == 0);
    return r;
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == w2s_pkg::REG_WIDTH) view_w = value[13:0];
    else if (idx == w2s_pkg::REG_HEIGHT) view_h = value[13:0];
    else pair_reg[idx] = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_matrix(logic [63:0] xa, logic [63:0] xb, logic [63:0] ya,
                              logic [63:0] yb, logic [63:0] wa, logic [63:0] wb);
    write_reg(w2s_pkg::REG_ROW_X_FIRST, xa);
    write_reg(w2s_pkg::REG_ROW_X_SECOND, xb);
    write_reg(w2s_pkg::REG_ROW_Y_FIRST, ya);
    write_reg(w2s_pkg::REG_ROW_Y_SECOND, yb);
    write_reg(w2s_pkg::REG_ROW_W_FIRST, wa);
    write_reg(w2s_pkg::REG_ROW_W_SECOND, wb);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(8192)) - 4096);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(bit wide);
    if (wide || $urandom_range(9) == 0) return $urandom;
    if ($urandom_range(5) == 0) return '0;
    return 32'($signed($urandom_range(4194304)) - 2097152);
  endfunction

  function automatic logic [63:0] rand_pair(bit wide);
    return {rand_coef(wide), rand_coef(wide)};
  endfunction

  task automatic add_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    w2s_pkg::in_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    point_q.push_back(p);
  endtask

  task automatic add_random(int n);
    repeat (n) add_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    while (point_q.size() != 0 || in_valid || projected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= point_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 0;
    end
  end

  // output ready, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 400;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    w2s_pkg::out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        projected_q.push_back(project_point(in_item));
        in_taken = 1;
      end
      if (out_valid && out_ready) begin
        if (projected_q.size() == 0) begin
          error_count++;
          $display("%t unexpected item x=%h y=%h w=%h z=%b", $time, out_item.screen_x,
                   out_item.screen_y, out_item.depth_w, out_item.depth_is_zero);
        end else begin
          want = projected_q.pop_front();
          if (out_item.screen_x !== want.screen_x || out_item.screen_y !== want.screen_y ||
              out_item.depth_w !== want.depth_w ||
              out_item.depth_is_zero !== want.depth_is_zero) begin
            error_count++;
            $display("%t mismatch expected x=%h y=%h w=%h z=%b actual x=%h y=%h w=%h z=%b",
                     $time, want.screen_x, want.screen_y, want.depth_w, want.depth_is_zero,
                     out_item.screen_x, out_item.screen_y, out_item.depth_w,
                     out_item.depth_is_zero);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 600000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    pair_reg[0] = w2s_pkg::PAIR_ONE_LOW;
    pair_reg[1] = '0;
    pair_reg[2] = w2s_pkg::PAIR_ONE_HIGH;
    pair_reg[3] = '0;
    pair_reg[4] = '0;
    pair_reg[5] = w2s_pkg::PAIR_ONE_HIGH;
    view_w = w2s_pkg::WIDTH_RESET;
    view_h = w2s_pkg::HEIGHT_RESET;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset matrix, field extremes, no idling
    add_point(24'h0, 24'h0, 24'h0);
    add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_point(24'h800000, 24'h800000, 24'h800000);
    add_point(24'h7FFFFF, 24'h800000, 24'h000001);
    add_point(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    add_point(24'h000100, 24'hFFFF00, 24'h000080);
    add_point(24'hFFFFFF, 24'h000001, 24'h555555);
    add_point(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    add_random(230);
    drain();

    // zero depth: w row cleared, both signs of clip x and y
    write_matrix(rand_pair(0), rand_pair(0), rand_pair(0), rand_pair(0), 64'h0, 64'h0);
    add_point(24'h0, 24'h0, 24'h0);
    add_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    add_point(24'h800000, 24'h800000, 24'h800000);
    add_point(24'h7FFFFF, 24'h800000, 24'h0);
    add_point(24'h800000, 24'h7FFFFF, 24'h0);
    add_random(200);
    send_idle_pct = 26;
    recv_idle_pct = 26;
    drain();

    // tiny viewport, w follows z so it crosses zero, sender idling
    write_reg(w2s_pkg::REG_WIDTH, 64'd1);
    write_reg(w2s_pkg::REG_HEIGHT, 64'd1);
    write_matrix(rand_pair(0), rand_pair(0), rand_pair(0), rand_pair(0),
                 64'h0, {32'h0, 32'h0010_0000});
    add_point(24'h0, 24'h0, 24'h1);
    add_point(24'h1000, 24'h1000, 24'hFFFFFF);
    add_random(200);
    send_idle_pct = 56;
    recv_idle_pct = 0;
    drain();

    // largest viewport, zero height, long receiver hold-off
    write_reg(w2s_pkg::REG_WIDTH, 64'h3FFF);
    write_reg(w2s_pkg::REG_HEIGHT, 64'h4000);
    write_matrix(rand_pair(0), rand_pair(0), rand_pair(0), rand_pair(0),
                 rand_pair(0), rand_pair(0));
    add_random(260);
    send_idle_pct = 0;
    recv_idle_pct = 56;
    hold_requests++;
    drain();

    // full-range coefficients
    write_reg(w2s_pkg::REG_WIDTH, 64'd8192);
    write_reg(w2s_pkg::REG_HEIGHT, 64'd0);
    write_matrix(rand_pair(1), rand_pair(1), rand_pair(1), rand_pair(1),
                 rand_pair(1), rand_pair(1));
    add_random(240);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    // extreme coefficients
    write_reg(w2s_pkg::REG_WIDTH, 64'h3FFF);
    write_reg(w2s_pkg::REG_HEIGHT, 64'h3FFF);
    write_matrix(64'h7FFFFFFF_80000000, 64'h80000000_7FFFFFFF, 64'hFFFFFFFF_7FFFFFFF,
                 64'h7FFFFFFF_FFFFFFFF, 64'h00000001_80000000, 64'h7FFFFFFF_00100000);
    add_random(240);
    send_idle_pct = 26;
    recv_idle_pct = 26;
    drain();

    // random matrices and viewports
    repeat (3) begin
      write_reg(w2s_pkg::REG_WIDTH, 64'($urandom_range(16383)));
      write_reg(w2s_pkg::REG_HEIGHT, 64'($urandom_range(16383)));
      write_matrix(rand_pair(0), rand_pair(0), rand_pair(0), rand_pair(0),
                   rand_pair(0), rand_pair(0));
      add_random(120);
      send_idle_pct = $urandom_range(1) ? 56 : 0;
      recv_idle_pct = $urandom_range(1) ? 56 : 0;
      drain();
    end

    // back to the reset setting
    write_reg(w2s_pkg::REG_WIDTH, 64'(w2s_pkg::WIDTH_RESET));
    write_reg(w2s_pkg::REG_HEIGHT, 64'(w2s_pkg::HEIGHT_RESET));
    write_matrix(w2s_pkg::PAIR_ONE_LOW, 64'h0, w2s_pkg::PAIR_ONE_HIGH, 64'h0, 64'h0,
                 w2s_pkg::PAIR_ONE_HIGH);
    add_random(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/w2s_pkg.sv
design/w2s_transform.sv
design/w2s_divider.sv
design/w2s_out_buffer.sv
design/world_to_screen_projection_top.sv
bench/testbench.sv
